FILE: design/bdec_pkg.sv
// ----------------------------------------------------------------------------
// bdec_pkg: shared types and constants of the binary to decimal ASCII unit
// Decade place weights, digit and character widths, and the structs that
// pass between the decade cells and the top level.
// ----------------------------------------------------------------------------
package bdec_pkg;

  // Default width of the converted value
  localparam int unsigned ValueBitsDef = 64;

  // Number of decade places, from 10^19 down to 10^0
  localparam int unsigned PlaceCount = 20;

  // Width of the weight constants: 9 * 10^19 still fits in 68 bits
  localparam int unsigned ConstBits = 68;

  // Largest decimal digit and the width of a digit
  localparam int unsigned DigitMax  = 9;
  localparam int unsigned DigitBits = 4;

  // Width of the character field and the code of '0'
  localparam int unsigned CharBits  = 6;
  localparam logic [CharBits-1:0] AsciiZero = 6'd48;

  // Control state that travels with an item from cell to cell
  typedef struct packed {
    logic valid;
    logic started;
  } cell_ctrl_t;

  // Digit that a cell offers to the output register
  typedef struct packed {
    logic                 emit;
    logic                 last;
    logic [DigitBits-1:0] digit;
  } cell_emit_t;

  // k times the weight of decade place 'place' (place 0 is 10^19)
  function automatic logic [ConstBits-1:0] place_mult(input int unsigned place,
                                                      input int unsigned k);
    logic [ConstBits-1:0] w;
    w = ConstBits'(1);
    for (int unsigned i = place + 1; i < PlaceCount; i++) begin
      w = w * ConstBits'(10);
    end
    return w * ConstBits'(k);
  endfunction

endpackage

FILE: design/bdec_cell.sv
// ----------------------------------------------------------------------------
// bdec_cell: one decade place of the conversion chain
// Holds the remainder of the item that sits in this place, resolves the
// digit of its weight and hands the reduced remainder to the next cell.
// ----------------------------------------------------------------------------
module bdec_cell
  import bdec_pkg::*;
#(
  parameter int unsigned VALUE_BITS = ValueBitsDef,
  parameter int unsigned PLACE      = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [VALUE_BITS-1:0] rest_i,
  output cell_ctrl_t            ctrl_o,
  output logic [VALUE_BITS-1:0] rest_o,
  output cell_emit_t            emit_o
);

  localparam bit IsOnes = (PLACE == PlaceCount - 1);

  cell_ctrl_t            ctrl_q;
  logic [VALUE_BITS-1:0] rest_q;

  logic [ConstBits-1:0]  rest_ext;
  logic [ConstBits:0]    diff [1:DigitMax];
  logic [DigitBits-1:0]  digit;

  // Take the item from the upstream neighbour
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (load_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rest_q <= rest_i;
    end
  end

  // Try every multiple of the weight at once; a borrow marks a miss
  always_comb begin
    rest_ext = {{(ConstBits - VALUE_BITS){1'b0}}, rest_q};
    for (int unsigned k = 1; k <= DigitMax; k++) begin
      diff[k] = {1'b0, rest_ext} - {1'b0, place_mult(PLACE, k)};
    end
  end

  // Keep the largest multiple that fits
  always_comb begin
    digit  = '0;
    rest_o = rest_q;
    for (int unsigned k = 1; k <= DigitMax; k++) begin
      if (!diff[k][ConstBits]) begin
        digit  = DigitBits'(k);
        rest_o = diff[k][VALUE_BITS-1:0];
      end
    end
  end

  // Pass control on; drop leading zeros except in the ones place
  always_comb begin
    ctrl_o.valid   = ctrl_q.valid;
    ctrl_o.started = ctrl_q.started | (digit != '0);
    emit_o.emit    = ctrl_q.valid & ((digit != '0) | ctrl_q.started | IsOnes);
    emit_o.last    = IsOnes;
    emit_o.digit   = digit;
  end

endmodule

FILE: design/binary_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit: unsigned binary to decimal ASCII digits
// Converts one value per input transfer into its decimal digits, most
// significant first, one output transfer per digit, ones digit flagged.
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  in       in_valid_i / in_ready_o   number_i[63:0]
//  out      out_valid_o / out_ready_i digit_char_o[5:0], last_digit_o
//
//  An item walks a chain of 20 decade cells, one cell per cycle while the
//  output does not stall; the next item is taken only once the ones cell
//  has handed its digit on, so the chain holds one item at a time.
//  Each cell resolves its digit combinationally against all nine multiples.
//  A stall on the output freezes the whole chain until the held digit goes.
//  Reset clears the cell control state and the output valid flag only.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_unit
  import bdec_pkg::*;
#(
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [63:0]         number_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CharBits-1:0] digit_char_o,
  output logic                last_digit_o
);

  cell_ctrl_t            ctrl_in  [PlaceCount];
  cell_ctrl_t            ctrl_out [PlaceCount];
  logic [VALUE_BITS-1:0] rest_in  [PlaceCount];
  logic [VALUE_BITS-1:0] rest_out [PlaceCount];
  cell_emit_t            emit     [PlaceCount];
  logic                  load     [PlaceCount];

  logic                  busy;
  logic                  accept;
  logic                  step;
  cell_emit_t            pick;

  logic                  out_valid_q, out_valid_d;
  logic [DigitBits-1:0]  digit_q, digit_d;
  logic                  last_q, last_d;

  // Chain is busy while any cell holds an item
  always_comb begin
    busy = 1'b0;
    for (int unsigned p = 0; p < PlaceCount; p++) begin
      busy = busy | ctrl_out[p].valid;
    end
  end

  assign in_ready_o = ~busy;
  assign accept     = in_valid_i & ~busy;
  assign step       = busy & (~out_valid_q | out_ready_i);

  // Feed the first cell from the input, the others from their neighbour
  always_comb begin
    for (int unsigned p = 0; p < PlaceCount; p++) begin
      if (p == 0) begin
        ctrl_in[p].valid   = accept;
        ctrl_in[p].started = 1'b0;
        rest_in[p]         = number_i[VALUE_BITS-1:0];
        load[p]            = accept | step;
      end else begin
        ctrl_in[p] = ctrl_out[p-1];
        rest_in[p] = rest_out[p-1];
        load[p]    = step;
      end
    end
  end

  for (genvar g = 0; g < PlaceCount; g++) begin : g_cell
    bdec_cell #(
      .VALUE_BITS(VALUE_BITS),
      .PLACE     (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .load_i (load[g]),
      .ctrl_i (ctrl_in[g]),
      .rest_i (rest_in[g]),
      .ctrl_o (ctrl_out[g]),
      .rest_o (rest_out[g]),
      .emit_o (emit[g])
    );
  end

  // Only the one occupied cell can offer a digit
  always_comb begin
    pick = '0;
    for (int unsigned p = 0; p < PlaceCount; p++) begin
      pick = pick | (emit[p].emit ? emit[p] : '0);
    end
  end

  // Load the output register on a step that emits, release it on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    digit_d     = digit_q;
    last_d      = last_q;
    priority if (step && pick.emit) begin
      out_valid_d = 1'b1;
      digit_d     = pick.digit;
      last_d      = pick.last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
    last_q  <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = AsciiZero + {{(CharBits - DigitBits){1'b0}}, digit_q};
  assign last_digit_o = last_q;

endmodule

FILE: design/bdec_checker.sv
// ----------------------------------------------------------------------------
// bdec_checker: port-level checks of the binary to decimal ASCII unit
// Watches the handshakes and digit stream of the top level over time.
// ----------------------------------------------------------------------------
module bdec_checker
  import bdec_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic [63:0]         number_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [CharBits-1:0] digit_char_o,
  input logic                last_digit_o
);

  // Hold a waiting input item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(number_i))
    else $error("waiting input item changed");

  // Hold a stalled digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(digit_char_o)
                                    && $stable(last_digit_o))
    else $error("stalled digit changed");

  // Emit decimal characters only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> digit_char_o >= AsciiZero
                    && digit_char_o <= AsciiZero + CharBits'(DigitMax))
    else $error("digit character out of range");

  // Refuse a new item while the current one still has digits to come
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_digit_o |-> !in_ready_o)
    else $error("input ready before the last digit");

  // Drop ready right after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while converting");

endmodule

bind binary_to_decimal_ascii_unit bdec_checker u_bdec_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .number_i     (number_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .digit_char_o (digit_char_o),
  .last_digit_o (last_digit_o)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the binary to decimal ASCII unit
// Sends 64-bit values and checks every digit transfer against a decimal
// expansion worked out here by repeated subtraction per decade place. Runs
// through phases of sender gaps and receiver stalls, plus one long hold-off
// on the output that backs the unit up until it stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
  import bdec_pkg::*;

  localparam int unsigned ValueBits   = ValueBitsDef;
  localparam logic [63:0] ValueMask   = (ValueBits >= 64) ? {64{1'b1}}
                                        : ((64'd1 << ValueBits) - 64'd1);
  localparam int unsigned RandomCount = 150;
  localparam int unsigned BurstCount  = 30;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned QuietLimit  = 5000;
  localparam int unsigned DrainCycles = 60;

  // One expected digit transfer
  typedef struct packed {
    logic [CharBits-1:0] digit_char;
    logic                last_digit;
  } digit_rec_t;

  // Expected digits of every accepted number, oldest first
  class digit_board;
    digit_rec_t  pending[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    static function logic [63:0] ten_pow(int unsigned k);
      logic [63:0] w;
      w = 64'd1;
      for (int unsigned i = 0; i < k; i++) w = w * 64'd10;
      return w;
    endfunction

    // Expand an accepted number into its decimal digits
    function void note_number(logic [63:0] value);
      logic [63:0]          rest;
      logic [63:0]          weight;
      logic [DigitBits-1:0] digit;
      bit                   started;
      bit                   ones;
      digit_rec_t           rec;
      rest    = value & ValueMask;
      started = 1'b0;
      for (int unsigned p = 0; p < PlaceCount; p++) begin
        weight = ten_pow(PlaceCount - 1 - p);
        digit  = '0;
        ones   = (p == PlaceCount - 1);
        while (rest >= weight && digit < DigitBits'(DigitMax)) begin
          rest  = rest - weight;
          digit = digit + DigitBits'(1);
        end
        if (digit != '0 || started || ones) begin
          rec.digit_char = AsciiZero + CharBits'(digit);
          rec.last_digit = ones;
          pending.push_back(rec);
          started = 1'b1;
        end
      end
    endfunction

    // Compare one output transfer with the oldest expected digit
    function void check_digit(logic [CharBits-1:0] digit_char, logic last_digit);
      digit_rec_t rec;
      if (pending.size() == 0) begin
        $error("unexpected digit: digit_char %0d last_digit %0b", digit_char, last_digit);
        errors++;
        return;
      end
      rec = pending.pop_front();
      if (digit_char !== rec.digit_char) begin
        $error("digit_char: expected %0d, got %0d", rec.digit_char, digit_char);
        errors++;
      end
      if (last_digit !== rec.last_digit) begin
        $error("last_digit: expected %0b, got %0b", rec.last_digit, last_digit);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [63:0]         number_i     = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [CharBits-1:0] digit_char_o;
  logic                last_digit_o;

  digit_board  board = new();
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req  = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  binary_to_decimal_ascii_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .number_i     (number_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

  always #5 clk_i = ~clk_i;

  // Offer one number, with random gaps first, and hold it until the transfer
  task automatic send_number(logic [63:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    number_i   <= value;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_number(value);
  endtask

  // Pick a value: mostly random widths, some near powers of ten, some full width
  function automatic logic [63:0] random_number();
    logic [63:0]  value;
    int unsigned  k;
    case ($urandom_range(7))
      0: begin
        k = $urandom_range(PlaceCount - 1);
        value = digit_board::ten_pow(k) - 64'($urandom_range(1));
      end
      1: value = {$urandom, $urandom};
      default: begin
        k = $urandom_range(64, 1);
        value = {$urandom, $urandom} >> (64 - k);
      end
    endcase
    return value;
  endfunction

  task automatic send_random(int unsigned count);
    repeat (count) send_number(random_number());
  endtask

  // Check output transfers and drive the receiver's stalls and hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        board.check_digit(digit_char_o, last_digit_o);
      end
      if (hold_req && !hold_done && hold_left == 0) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Abort when no transfer happens on either channel for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed values: zero, single digits, decade edges, extremes
    send_number(64'd0);
    send_number(64'd1);
    send_number(64'd9);
    send_number(64'd10);
    send_number(64'd11);
    send_number(64'd99);
    send_number(64'd100);
    send_number(64'd1000000000);
    send_number(64'd9999999999);
    send_number(64'hFFFF_FFFF);
    send_number(64'h1_0000_0000);
    send_number(64'd1234567890123456789);
    send_number(64'd9999999999999999999);
    send_number(64'd10000000000000000000);
    send_number(64'd18000000000000000000);
    send_number(64'h8000_0000_0000_0000);
    send_number(64'hAAAA_AAAA_AAAA_AAAA);
    send_number(64'h5555_5555_5555_5555);
    send_number(64'hFFFF_FFFF_FFFF_FFFE);
    send_number(64'hFFFF_FFFF_FFFF_FFFF);

    // Phases of idling on either side
    send_random(RandomCount / 4);
    send_idle_pct  = 79;
    send_random(RandomCount / 4);
    send_idle_pct  = 0;
    recv_stall_pct = 79;
    send_random(RandomCount / 4);
    send_idle_pct  = 26;
    recv_stall_pct = 26;
    send_random(RandomCount / 4);

    // Hold the output off while the sender keeps offering
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    send_random(BurstCount);

    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
